// ===== design/sers_pkg.sv =====
// ----------------------------------------------------------------------------
// sers_pkg
// Shared types, widths and codes for the SCAN elevator request scheduler.
// ----------------------------------------------------------------------------
package sers_pkg;

	// Queue geometry and field widths
	localparam int QUEUE_DEPTH = 32;
	localparam int SECTOR_BITS = 48;
	localparam int LEN_W       = 16;
	localparam int TAG_W       = 8;
	localparam int HEAD_W      = SECTOR_BITS + 1;
	localparam int DIST_W      = SECTOR_BITS + 1;
	localparam int SUM_W       = 64;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_W     = SECTOR_BITS + LEN_W + TAG_W;

	localparam logic [LVL_W-1:0] LEVEL_MAX = LVL_W'(QUEUE_DEPTH);

	// Result status codes
	localparam logic [1:0] ST_ENQUEUED   = 2'd0;
	localparam logic [1:0] ST_FULL       = 2'd1;
	localparam logic [1:0] ST_DISPATCHED = 2'd2;
	localparam logic [1:0] ST_EMPTY      = 2'd3;

	// Action codes
	localparam logic ACT_ENQUEUE  = 1'b0;
	localparam logic ACT_DISPATCH = 1'b1;

	// Index register operations
	localparam logic [2:0] IDX_HOLD    = 3'd0;
	localparam logic [2:0] IDX_LD_INS  = 3'd1;
	localparam logic [2:0] IDX_LD_SCAN = 3'd2;
	localparam logic [2:0] IDX_INC     = 3'd3;
	localparam logic [2:0] IDX_DEC     = 3'd4;

	// Read address offset from the next index
	localparam logic [1:0] RD_AT    = 2'd0;
	localparam logic [1:0] RD_BELOW = 2'd1;
	localparam logic [1:0] RD_ABOVE = 2'd2;

	typedef struct packed {
		logic                   action;
		logic [SECTOR_BITS-1:0] request_sector;
		logic [LEN_W-1:0]       request_length;
		logic [TAG_W-1:0]       request_tag;
	} req_in_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [SECTOR_BITS-1:0] out_sector;
		logic [LEN_W-1:0]       out_length;
		logic [TAG_W-1:0]       out_tag;
		logic                   sweep_up;
		logic [DIST_W-1:0]      seek_distance;
		logic [SUM_W-1:0]       seek_sum;
		logic [LVL_W-1:0]       queue_level;
	} res_out_t;

	typedef struct packed {
		logic [SECTOR_BITS-1:0] sector;
		logic [LEN_W-1:0]       length;
		logic [TAG_W-1:0]       tag;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic       req_ld;
		logic [2:0] idx_op;
		logic [1:0] rd_off;
		logic       wr_en;
		logic       wr_new;
		logic       pick_ld;
		logic       turn;
		logic       head_upd;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       res_ld;
		logic [1:0] res_status;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_dispatch;
		logic full;
		logic empty;
		logic new_lt;
		logic hit;
		logic scan_end;
		logic idx_one;
		logic idx_last;
		logic shift_end;
		logic dir_up;
		logic out_free;
	} stat_t;

endpackage

// ===== design/sers_ram.sv =====
// ----------------------------------------------------------------------------
// sers_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sers_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write when enabled, read every cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== design/sers_dpath.sv =====
// ----------------------------------------------------------------------------
// sers_dpath
// Datapath: sorted request queue in RAM, walk index, head, direction,
// seek total and the result register.
// ----------------------------------------------------------------------------
module sers_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  sers_pkg::req_in_t in_data,
	input  logic              out_ready,
	output logic              out_valid,
	output sers_pkg::res_out_t out_data,
	input  sers_pkg::cmd_t    cmd,
	output sers_pkg::stat_t   stat
);

	localparam int IW = sers_pkg::IDX_W;
	localparam int LW = sers_pkg::LVL_W;
	localparam int HW = sers_pkg::HEAD_W;

	sers_pkg::entry_t           req_q;
	sers_pkg::entry_t           pick_q;
	sers_pkg::entry_t           rd_data;
	sers_pkg::entry_t           wr_data;
	logic [IW-1:0]              idx_q;
	logic [IW-1:0]              idx_d;
	logic [IW-1:0]              rd_addr;
	logic [LW-1:0]              count_q;
	logic [HW-1:0]              head_q;
	logic                       dir_q;
	logic [sers_pkg::SUM_W-1:0] sum_q;
	logic [sers_pkg::DIST_W-1:0] dist_q;
	logic [HW-1:0]              rd_sec;
	logic                       out_valid_q;
	sers_pkg::res_out_t         out_data_q;
	logic                       disp;

	// Next walk index
	always_comb begin
		case (cmd.idx_op)
			sers_pkg::IDX_LD_INS:  idx_d = IW'(count_q);
			sers_pkg::IDX_LD_SCAN: idx_d = dir_q ? '0 : IW'(count_q - LW'(1));
			sers_pkg::IDX_INC:     idx_d = idx_q + IW'(1);
			sers_pkg::IDX_DEC:     idx_d = idx_q - IW'(1);
			default:               idx_d = idx_q;
		endcase
	end

	// Read address relative to the next index
	always_comb begin
		case (cmd.rd_off)
			sers_pkg::RD_BELOW: rd_addr = idx_d - IW'(1);
			sers_pkg::RD_ABOVE: rd_addr = idx_d + IW'(1);
			default:            rd_addr = idx_d;
		endcase
	end

	assign wr_data = cmd.wr_new ? req_q : rd_data;

	sers_ram #(
		.WIDTH(sers_pkg::ENTRY_W),
		.DEPTH(sers_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.wr_en  (cmd.wr_en),
		.wr_addr(idx_q),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rd_sec = {1'b0, rd_data.sector};

	// Status toward the controller
	always_comb begin
		stat.in_dispatch = (in_data.action == sers_pkg::ACT_DISPATCH);
		stat.full        = (count_q == sers_pkg::LEVEL_MAX);
		stat.empty       = (count_q == '0);
		stat.new_lt      = (req_q.sector < rd_data.sector);
		stat.hit         = dir_q ? (rd_sec >= head_q) : (rd_sec <= head_q);
		stat.idx_one     = (idx_q == IW'(1));
		stat.idx_last    = ((LW'(idx_q) + LW'(1)) == count_q);
		stat.shift_end   = ((LW'(idx_q) + LW'(2)) == count_q);
		stat.scan_end    = dir_q ? stat.idx_last : (idx_q == '0);
		stat.dir_up      = dir_q;
		stat.out_free    = !out_valid_q || out_ready;
	end

	// Payload registers
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (cmd.req_ld) begin
			req_q.sector <= in_data.request_sector;
			req_q.length <= in_data.request_length;
			req_q.tag    <= in_data.request_tag;
		end
		if (cmd.pick_ld) begin
			pick_q <= rd_data;
			dist_q <= (rd_sec > head_q) ? (rd_sec - head_q) : (head_q - rd_sec);
		end
	end

	// Scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= '0;
			dir_q   <= 1'b1;
			sum_q   <= '0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + LW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - LW'(1);
			end
			if (cmd.pick_ld && cmd.turn) begin
				dir_q <= ~dir_q;
			end
			if (cmd.head_upd) begin
				head_q <= HW'(pick_q.sector) + HW'(pick_q.length);
				sum_q  <= sum_q + sers_pkg::SUM_W'(dist_q);
			end
		end
	end

	// Result register
	assign disp = (cmd.res_status == sers_pkg::ST_DISPATCHED);

	always_ff @(posedge clk) begin
		if (cmd.res_ld) begin
			out_data_q.status        <= cmd.res_status;
			out_data_q.out_sector    <= disp ? pick_q.sector : '0;
			out_data_q.out_length    <= disp ? pick_q.length : '0;
			out_data_q.out_tag       <= disp ? pick_q.tag : '0;
			out_data_q.sweep_up      <= dir_q;
			out_data_q.seek_distance <= disp ? dist_q : '0;
			out_data_q.seek_sum      <= sum_q;
			out_data_q.queue_level   <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.res_ld || (out_valid_q && !out_ready);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== design/sers_ctrl.sv =====
// ----------------------------------------------------------------------------
// sers_ctrl
// Controller: sequences insertion, scan, removal and the result beat.
// ----------------------------------------------------------------------------
module sers_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sers_pkg::stat_t stat,
	output sers_pkg::cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_INS   = 3'd1;
	localparam logic [2:0] S_PUT   = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_ADV   = 3'd4;
	localparam logic [2:0] S_SHIFT = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] res_q;
	logic [1:0] res_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		res_d          = res_q;
		cmd            = '0;
		cmd.idx_op     = sers_pkg::IDX_HOLD;
		cmd.rd_off     = sers_pkg::RD_AT;
		cmd.res_status = res_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.req_ld = 1'b1;
					if (!stat.in_dispatch) begin
						if (stat.full) begin
							res_d   = sers_pkg::ST_FULL;
							state_d = S_FIN;
						end else begin
							cmd.idx_op = sers_pkg::IDX_LD_INS;
							cmd.rd_off = sers_pkg::RD_BELOW;
							state_d    = stat.empty ? S_PUT : S_INS;
						end
					end else if (stat.empty) begin
						res_d   = sers_pkg::ST_EMPTY;
						state_d = S_FIN;
					end else begin
						cmd.idx_op = sers_pkg::IDX_LD_SCAN;
						cmd.rd_off = sers_pkg::RD_AT;
						state_d    = S_SCAN;
					end
				end
			end
			// Move larger entries up one slot until the new one fits
			S_INS: begin
				if (stat.new_lt) begin
					cmd.wr_en  = 1'b1;
					cmd.idx_op = sers_pkg::IDX_DEC;
					cmd.rd_off = sers_pkg::RD_BELOW;
					if (stat.idx_one) begin
						state_d = S_PUT;
					end
				end else begin
					cmd.wr_en   = 1'b1;
					cmd.wr_new  = 1'b1;
					cmd.cnt_inc = 1'b1;
					res_d       = sers_pkg::ST_ENQUEUED;
					state_d     = S_FIN;
				end
			end
			S_PUT: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_new  = 1'b1;
				cmd.cnt_inc = 1'b1;
				res_d       = sers_pkg::ST_ENQUEUED;
				state_d     = S_FIN;
			end
			// Walk in the sweep direction; the far end is the turnaround pick
			S_SCAN: begin
				if (stat.hit || stat.scan_end) begin
					cmd.pick_ld = 1'b1;
					cmd.turn    = !stat.hit;
					state_d     = S_ADV;
				end else begin
					cmd.idx_op = stat.dir_up ? sers_pkg::IDX_INC : sers_pkg::IDX_DEC;
					cmd.rd_off = sers_pkg::RD_AT;
				end
			end
			S_ADV: begin
				cmd.head_upd = 1'b1;
				cmd.rd_off   = sers_pkg::RD_ABOVE;
				if (stat.idx_last) begin
					cmd.cnt_dec = 1'b1;
					res_d       = sers_pkg::ST_DISPATCHED;
					state_d     = S_FIN;
				end else begin
					state_d = S_SHIFT;
				end
			end
			// Close the gap left by the picked entry
			S_SHIFT: begin
				cmd.wr_en  = 1'b1;
				cmd.idx_op = sers_pkg::IDX_INC;
				cmd.rd_off = sers_pkg::RD_ABOVE;
				if (stat.shift_end) begin
					cmd.cnt_dec = 1'b1;
					res_d       = sers_pkg::ST_DISPATCHED;
					state_d     = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.res_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

endmodule

// ===== design/scan_elevator_request_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// scan_elevator_request_scheduler_top
// SCAN elevator scheduler: sorted request queue, sweep dispatch, seek total.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  in       in   in_valid / in_ready   in_data  (sers_pkg::req_in_t)
//  out      out  out_valid / out_ready out_data (sers_pkg::res_out_t)
//
//  One item at a time through the single read port of the queue RAM.
//  Enqueue: accept, move each larger entry up one slot, write the new entry,
//  then load the result. Dispatch: accept, scan in the sweep direction, pick,
//  move each entry above the pick down, then load the result. Full, empty: accept, load the result.
//  Reset empties the queue, sets the head to 0 and the sweep up.
//  in_ready rises again once the result beat sits in the output register; a
//  stalled output holds the next result back until it is taken.
// ----------------------------------------------------------------------------
module scan_elevator_request_scheduler_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sers_pkg::req_in_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output sers_pkg::res_out_t out_data
);

	sers_pkg::cmd_t  cmd;
	sers_pkg::stat_t stat;

	sers_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	sers_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_data (out_data),
		.cmd      (cmd),
		.stat     (stat)
	);

`ifndef SYNTHESIS
	// One item in flight: an accepted beat drops ready
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready held after accepting a beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.queue_level <= sers_pkg::LEVEL_MAX))
		else $error("queue level beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.status != sers_pkg::ST_DISPATCHED)) |->
		((out_data.seek_distance == '0) && (out_data.out_sector == '0)))
		else $error("non-dispatch beat carries request fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.status == sers_pkg::ST_EMPTY)) |->
		(out_data.queue_level == '0))
		else $error("empty status with queued requests");
`endif

endmodule
